>>> sv/gbrm_pkg.sv
// Package for the granule bitmap range marker: payload structs, command codes,
// controller/datapath command and status structs, shared widths and defaults.
// No dependencies.
`default_nettype none

package gbrm_pkg;

	// Field widths of one command and one result
	localparam int CMD_W      = 2;
	localparam int START_W    = 20;
	localparam int ADDR_W     = 21;
	localparam int WORD_IDX_W = 10;
	localparam int WORD_W     = 64;

	// Granule indexes fit the widest address; word indexes cover the largest bitmap
	localparam int GIDX_W = ADDR_W;
	localparam int WIDX_W = 17;
	localparam int LSB_W  = $clog2(WORD_W);

	// Reciprocal multiplier constant width
	localparam int MUL_W = ADDR_W + 1;

	// Defaults for the top-level parameters
	localparam int DEF_GRANULE_BYTES = 16;
	localparam int DEF_BITMAP_WORDS  = 1024;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	// Multiplier operand select
	localparam logic [1:0] MOP_LEN   = 2'd0;
	localparam logic [1:0] MOP_START = 2'd1;
	localparam logic [1:0] MOP_LAST  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [START_W-1:0]    range_start;
		logic [ADDR_W-1:0]     range_end;
		logic [WORD_IDX_W-1:0] word_index;
	} gbrm_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic              done_res;
	} gbrm_res_t;

	// Controller -> datapath
	typedef struct packed {
		logic       ld_item;
		logic       clr_res;
		logic       ld_res;
		logic       rd_item;
		logic       rd_walk;
		logic [1:0] mul_sel;
		logic       q_len;
		logic       q_first;
		logic       q_last;
		logic       setup;
		logic       wr;
		logic       clr;
		logic       w_inc;
	} gbrm_ctl_t;

	// Datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             walk_go;
		logic             need_read;
		logic             clr_last;
	} gbrm_sts_t;

endpackage

`default_nettype wire

>>> sv/granule_bitmap_range_marker.sv
// Top level of the granule bitmap range marker: controller plus datapath.
// Depends on gbrm_pkg, gbrm_ctrl and gbrm_dp.
`default_nettype none

// Keeps one bit per GRANULE_BYTES-byte granule in BITMAP_WORDS 64-bit words.
// A command is taken on a clock edge with start high and busy low; exactly one
// result comes back per command, on result for a single cycle flagged by
// result_strobe, and it must be taken then - there is no way to stall it.
// After reset the block runs a clearing pass, one word per cycle, and holds
// busy high until every word is cleared, before the first transfer. A read
// fetches the addressed word; an empty range or an unused command returns
// its result with no memory access. A set/clear runs the divide sequence (one
// shared reciprocal multiplier used for the length, first and last granule)
// plus mask setup, then walks the words of the single-port bitmap memory:
// first and last words are read-modify-write, middle words are written
// directly. Words that fall past the end of the bitmap are skipped.

module granule_bitmap_range_marker #(
	parameter int GRANULE_BYTES = gbrm_pkg::DEF_GRANULE_BYTES,
	parameter int BITMAP_WORDS  = gbrm_pkg::DEF_BITMAP_WORDS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire gbrm_pkg::gbrm_in_t   item,
	output logic                      result_strobe,
	output gbrm_pkg::gbrm_res_t       result
);

	gbrm_pkg::gbrm_ctl_t ctl;
	gbrm_pkg::gbrm_sts_t sts;

	gbrm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.sts           (sts),
		.ctl           (ctl),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	gbrm_dp #(
		.GRANULE_BYTES (GRANULE_BYTES),
		.BITMAP_WORDS  (BITMAP_WORDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire

>>> sv/gbrm_dp.sv
// Datapath of the granule bitmap range marker: command register, shared
// reciprocal multiplier, mask builder, word walker and the bitmap memory.
// Depends on gbrm_pkg.
`default_nettype none

module gbrm_dp #(
	parameter int GRANULE_BYTES = gbrm_pkg::DEF_GRANULE_BYTES,
	parameter int BITMAP_WORDS  = gbrm_pkg::DEF_BITMAP_WORDS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire gbrm_pkg::gbrm_in_t   item,
	input  wire gbrm_pkg::gbrm_ctl_t  ctl,
	output gbrm_pkg::gbrm_sts_t       sts,
	output gbrm_pkg::gbrm_res_t       result
);

	localparam int AW  = $clog2(BITMAP_WORDS);
	localparam int GL  = $clog2(GRANULE_BYTES);
	localparam int SH  = gbrm_pkg::ADDR_W + GL;
	localparam longint unsigned MUL_FULL =
		((64'd1 << SH) + longint'(GRANULE_BYTES) - 64'd1) / longint'(GRANULE_BYTES);
	localparam logic [gbrm_pkg::MUL_W-1:0] MUL_C = MUL_FULL[gbrm_pkg::MUL_W-1:0];
	localparam int PROD_W = gbrm_pkg::ADDR_W + gbrm_pkg::MUL_W;

	localparam logic [gbrm_pkg::WIDX_W-1:0] NWORDS   = gbrm_pkg::WIDX_W'(BITMAP_WORDS);
	localparam logic [gbrm_pkg::WIDX_W-1:0] LAST_IDX = gbrm_pkg::WIDX_W'(BITMAP_WORDS - 1);
	localparam logic [gbrm_pkg::WORD_W-1:0] ONES     = '1;

	gbrm_pkg::gbrm_in_t              item_q;
	logic [PROD_W-1:0]               prod_q;
	logic [gbrm_pkg::GIDX_W-1:0]     width_q, gf_q, gl_q;
	logic [gbrm_pkg::WIDX_W-1:0]     w_first_q, w_last_q, w_cur_q;
	logic [gbrm_pkg::WORD_W-1:0]     mask_first_q, mask_last_q;
	logic [gbrm_pkg::WORD_W-1:0]     rd_q, res_q;
	logic                            rd_ok_q;
	logic [gbrm_pkg::WORD_W-1:0]     mem [BITMAP_WORDS];

	logic [gbrm_pkg::ADDR_W-1:0]     start_x, mul_a;
	logic [gbrm_pkg::GIDX_W-1:0]     quo;
	logic [gbrm_pkg::WIDX_W-1:0]     wf_c, wl_c, idx_x;
	logic [gbrm_pkg::LSB_W-1:0]      lsb, msb, hi;
	logic [gbrm_pkg::LSB_W:0]        room;
	logic [gbrm_pkg::WORD_W-1:0]     from_lsb, sgl_mask, mask, merged, wdata;
	logic                            in_range, is_first, is_last;
	logic [AW-1:0]                   raddr;

	assign start_x = {1'b0, item_q.range_start};

	always_comb begin
		case (ctl.mul_sel)
			gbrm_pkg::MOP_LEN:   mul_a = item_q.range_end - start_x;
			gbrm_pkg::MOP_START: mul_a = start_x;
			gbrm_pkg::MOP_LAST:  mul_a = item_q.range_end - gbrm_pkg::ADDR_W'(1);
			default:             mul_a = '0;
		endcase
	end

	// floor(x / GRANULE_BYTES) as (x * ceil(2^SH / G)) >> SH, exact for 21-bit x
	assign quo = gbrm_pkg::GIDX_W'(prod_q >> SH);

	// Mask builder
	assign wf_c     = gbrm_pkg::WIDX_W'(gf_q >> gbrm_pkg::LSB_W);
	assign wl_c     = gbrm_pkg::WIDX_W'(gl_q >> gbrm_pkg::LSB_W);
	assign lsb      = gf_q[gbrm_pkg::LSB_W-1:0];
	assign msb      = gl_q[gbrm_pkg::LSB_W-1:0];
	assign room     = (gbrm_pkg::LSB_W+1)'(gbrm_pkg::WORD_W) - {1'b0, lsb};
	assign from_lsb = ONES << lsb;
	assign hi       = (width_q >= gbrm_pkg::GIDX_W'(room)) ? '1 :
	                  lsb + width_q[gbrm_pkg::LSB_W-1:0] - gbrm_pkg::LSB_W'(1);
	assign sgl_mask = (width_q == '0) ? '0 : (from_lsb & (ONES >> (~hi)));

	// Word walker; middle words take the all-ones mask, so the stale read data drops out
	assign in_range = w_cur_q < NWORDS;
	assign is_first = w_cur_q == w_first_q;
	assign is_last  = w_cur_q == w_last_q;
	assign mask     = is_first ? mask_first_q : (is_last ? mask_last_q : ONES);
	assign merged   = (item_q.cmd == gbrm_pkg::CMD_SET) ? (rd_q | mask) : (rd_q & ~mask);
	assign wdata    = ctl.clr ? '0 : merged;

	assign idx_x = gbrm_pkg::WIDX_W'(item_q.word_index);
	assign raddr = ctl.rd_item ? idx_x[AW-1:0] : w_cur_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.ld_item)
			item_q <= item;
		prod_q <= PROD_W'(mul_a) * PROD_W'(MUL_C);
		if (ctl.q_len)
			width_q <= quo;
		if (ctl.q_first)
			gf_q <= quo;
		if (ctl.q_last)
			gl_q <= quo;
		if (ctl.setup) begin
			w_first_q    <= wf_c;
			w_last_q     <= wl_c;
			mask_first_q <= (wf_c == wl_c) ? sgl_mask : from_lsb;
			mask_last_q  <= ONES >> (~msb);
		end
		if (ctl.rd_item)
			rd_ok_q <= idx_x < NWORDS;
		if (ctl.clr_res)
			res_q <= '0;
		else if (ctl.ld_res)
			res_q <= rd_ok_q ? rd_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			w_cur_q <= '0;
		else if (ctl.setup)
			w_cur_q <= wf_c;
		else if (ctl.w_inc)
			w_cur_q <= w_cur_q + gbrm_pkg::WIDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_item || ctl.rd_walk)
			rd_q <= mem[raddr];
		if (ctl.wr)
			mem[w_cur_q[AW-1:0]] <= wdata;
	end

	assign sts.cmd       = item_q.cmd;
	assign sts.empty     = item_q.range_end <= start_x;
	assign sts.walk_go   = in_range && (w_cur_q <= w_last_q);
	assign sts.need_read = is_first || is_last;
	assign sts.clr_last  = w_cur_q == LAST_IDX;

	assign result.read_word = res_q;
	assign result.done_res  = 1'b1;

endmodule

`default_nettype wire

>>> sv/gbrm_ctrl.sv
// Controller of the granule bitmap range marker: clearing pass, command
// dispatch, divide sequence, word walk and result strobe.
// Depends on gbrm_pkg.
`default_nettype none

module gbrm_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire gbrm_pkg::gbrm_sts_t  sts,
	output gbrm_pkg::gbrm_ctl_t       ctl,
	output logic                      busy,
	output logic                      result_strobe
);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DISP  = 4'd2;
	localparam logic [3:0] ST_RDW   = 4'd3;
	localparam logic [3:0] ST_MUL0  = 4'd4;
	localparam logic [3:0] ST_MUL1  = 4'd5;
	localparam logic [3:0] ST_MUL2  = 4'd6;
	localparam logic [3:0] ST_MUL3  = 4'd7;
	localparam logic [3:0] ST_SETUP = 4'd8;
	localparam logic [3:0] ST_WALK  = 4'd9;
	localparam logic [3:0] ST_WR    = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       is_mark;

	assign is_mark = (sts.cmd == gbrm_pkg::CMD_SET) || (sts.cmd == gbrm_pkg::CMD_CLEAR);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_CLR: begin
				ctl.wr    = 1'b1;
				ctl.clr   = 1'b1;
				ctl.w_inc = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					ctl.ld_item = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				ctl.clr_res = 1'b1;
				if (sts.cmd == gbrm_pkg::CMD_READ) begin
					ctl.rd_item = 1'b1;
					state_d     = ST_RDW;
				end else if (is_mark && !sts.empty) begin
					state_d = ST_MUL0;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RDW: begin
				ctl.ld_res = 1'b1;
				state_d    = ST_FIN;
			end
			ST_MUL0: begin
				ctl.mul_sel = gbrm_pkg::MOP_LEN;
				state_d     = ST_MUL1;
			end
			ST_MUL1: begin
				ctl.mul_sel = gbrm_pkg::MOP_START;
				ctl.q_len   = 1'b1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				ctl.mul_sel = gbrm_pkg::MOP_LAST;
				ctl.q_first = 1'b1;
				state_d     = ST_MUL3;
			end
			ST_MUL3: begin
				ctl.q_last = 1'b1;
				state_d    = ST_SETUP;
			end
			ST_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (!sts.walk_go) begin
					state_d = ST_FIN;
				end else if (sts.need_read) begin
					ctl.rd_walk = 1'b1;
					state_d     = ST_WR;
				end else begin
					ctl.wr    = 1'b1;
					ctl.w_inc = 1'b1;
				end
			end
			ST_WR: begin
				ctl.wr    = 1'b1;
				ctl.w_inc = 1'b1;
				state_d   = ST_WALK;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	assign busy          = state_q != ST_IDLE;
	assign result_strobe = state_q == ST_FIN;

endmodule

`default_nettype wire
